>>> src/nrmc_pkg.sv
// Shared types and constants for the NMEA RMC time/date parser.
// No dependencies; used by nrmc_hdr_match and nmea_rmc_time_date_parser.
package nrmc_pkg;

  typedef logic [7:0] char_t;

  localparam char_t CHAR_DOLLAR = 8'h24;
  localparam char_t CHAR_COMMA  = 8'h2C;
  localparam char_t CHAR_A      = 8'h41;
  localparam char_t CHAR_G      = 8'h47;
  localparam char_t CHAR_0      = 8'h30;
  localparam char_t CHAR_9      = 8'h39;

  localparam int HDR_LEN = 5;

  // field numbers, counted by commas
  localparam logic [3:0] FIELD_TIME   = 4'd1;
  localparam logic [3:0] FIELD_ACTIVE = 4'd2;
  localparam logic [3:0] FIELD_DATE   = 4'd9;
  localparam logic [3:0] COMMA_MAX    = 4'd15;

  localparam logic [2:0] POS_MAX   = 3'd7;
  localparam logic [2:0] POS_LIMIT = 3'd6;

  localparam logic [11:0] YEAR_BASE = 12'd2000;

  typedef logic [1:0] status_t;
  localparam status_t STATUS_OK      = 2'd0;
  localparam status_t STATUS_INVALID = 2'd1;
  localparam status_t STATUS_ERROR   = 2'd2;

  // characters of the sentence header "GPRMC"
  function automatic char_t hdr_char(input logic [2:0] idx);
    char_t c;
    case (idx)
      3'd0:    c = 8'h47;
      3'd1:    c = 8'h50;
      3'd2:    c = 8'h52;
      3'd3:    c = 8'h4D;
      3'd4:    c = 8'h43;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

>>> src/nrmc_hdr_match.sv
// Streaming matcher for the "GPRMC" header anywhere in the sentence.
// Depends on nrmc_pkg.
module nrmc_hdr_match (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            take,       // character accepted this cycle
  input  logic            last,       // accepted character ends the sentence
  input  nrmc_pkg::char_t ch,
  output logic            found_nxt   // header seen, including this character
);

  logic [2:0] progress_r, progress_nxt;
  logic       found_r;
  logic [2:0] prog_step;
  logic       hit;

  always_comb begin
    prog_step = progress_r;
    hit       = 1'b0;
    if (!found_r) begin
      if (ch == nrmc_pkg::hdr_char(progress_r)) begin
        prog_step = progress_r + 3'd1;
      end else if (ch == nrmc_pkg::CHAR_G) begin
        prog_step = 3'd1;
      end else begin
        prog_step = 3'd0;
      end
      if (prog_step >= 3'(nrmc_pkg::HDR_LEN)) begin
        hit       = 1'b1;
        prog_step = 3'd0;
      end
    end
    progress_nxt = prog_step;
    found_nxt    = found_r | hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      progress_r <= 3'd0;
      found_r    <= 1'b0;
    end else if (take) begin
      if (last) begin
        progress_r <= 3'd0;
        found_r    <= 1'b0;
      end else begin
        progress_r <= progress_nxt;
        found_r    <= found_nxt;
      end
    end
  end

endmodule

>>> src/nmea_rmc_time_date_parser.sv
// Top level of the NMEA RMC time/date parser: per-character field tracking,
// digit-pair accumulation and the result register. Depends on nrmc_pkg, nrmc_hdr_match.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one character per request,
//   with in_end_of_sentence marking the final character of a sentence.
//   Result channel (out_valid / out_stall) carries one request per sentence:
//   status plus hours, minutes, seconds, day, month and year.
//   cfg_we / cfg_wdata write the second offset; write it only while idle.
// Timing:
//   One character per cycle is sustained, but for the hold described below.
//   The result appears in the cycle after the final character
//   is accepted. Only the final character of a sentence waits on the result
//   register: it is held off while a previous result sits stalled there;
//   all other characters keep flowing.
// Reset:
//   Synchronous active-low reset clears the parser state, drops any held
//   result and sets the second offset to zero. Parser state also returns
//   to its reset value after every sentence.
module nmea_rmc_time_date_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_byte,
  input  logic        in_end_of_sentence,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [6:0]  out_hours,
  output logic [6:0]  out_minutes,
  output logic [7:0]  out_seconds,
  output logic [6:0]  out_day,
  output logic [6:0]  out_month,
  output logic [11:0] out_year
);

  logic [5:0] offset_r;

  logic       first_r, first_nxt;
  logic       dollar_r, dollar_nxt;
  logic [3:0] comma_r, comma_nxt;
  logic [2:0] pos_r, pos_nxt;
  logic       active_r, active_nxt;
  logic       stopped_r, stopped_nxt;
  logic [6:0] hour_r, hour_nxt, minute_r, minute_nxt, second_r, second_nxt;
  logic [6:0] day_r, day_nxt, month_r, month_nxt, year_r, year_nxt;

  logic       take, last, found_nxt;
  logic       is_digit, in_field, stop_base;
  logic [1:0] pair;
  logic [3:0] dval;
  logic [6:0] acc_cur, acc_new;
  logic [10:0] acc_wide;

  logic        out_valid_r;
  logic [1:0]  status_r;
  logic [6:0]  o_hour_r, o_minute_r, o_day_r, o_month_r;
  logic [7:0]  o_second_r;
  logic [11:0] o_year_r;
  logic [1:0]  status_nxt;

  // hold the final character while a stalled result still occupies the output
  assign in_stall = out_valid_r && out_stall && in_end_of_sentence;
  assign take     = in_valid && !in_stall;
  assign last     = take && in_end_of_sentence;

  nrmc_hdr_match u_hdr (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .last      (last),
    .ch        (in_char_byte),
    .found_nxt (found_nxt)
  );

  always_comb begin
    first_nxt   = 1'b0;
    dollar_nxt  = first_r ? (in_char_byte == nrmc_pkg::CHAR_DOLLAR) : dollar_r;
    comma_nxt   = comma_r;
    pos_nxt     = pos_r;
    active_nxt  = active_r;
    stopped_nxt = stopped_r;
    hour_nxt    = hour_r;
    minute_nxt  = minute_r;
    second_nxt  = second_r;
    day_nxt     = day_r;
    month_nxt   = month_r;
    year_nxt    = year_r;

    is_digit  = (in_char_byte >= nrmc_pkg::CHAR_0) && (in_char_byte <= nrmc_pkg::CHAR_9);
    dval      = 4'(in_char_byte - nrmc_pkg::CHAR_0);
    pair      = pos_r[2:1];
    in_field  = (pos_r < nrmc_pkg::POS_LIMIT) &&
                ((comma_r == nrmc_pkg::FIELD_TIME) || (comma_r == nrmc_pkg::FIELD_DATE));
    stop_base = pos_r[0] ? stopped_r : 1'b0;

    case ({comma_r == nrmc_pkg::FIELD_DATE, pair})
      3'b000:  acc_cur = hour_r;
      3'b001:  acc_cur = minute_r;
      3'b010:  acc_cur = second_r;
      3'b100:  acc_cur = day_r;
      3'b101:  acc_cur = month_r;
      3'b110:  acc_cur = year_r;
      default: acc_cur = 7'd0;
    endcase
    acc_wide = 11'(acc_cur) * 11'd10 + 11'(dval);
    acc_new  = acc_wide[6:0];

    if (in_char_byte == nrmc_pkg::CHAR_COMMA) begin
      if (comma_r < nrmc_pkg::COMMA_MAX) begin
        comma_nxt = comma_r + 4'd1;
      end
      pos_nxt     = 3'd0;
      stopped_nxt = 1'b0;
    end else begin
      if (comma_r == nrmc_pkg::FIELD_ACTIVE && pos_r == 3'd0 &&
          in_char_byte == nrmc_pkg::CHAR_A) begin
        active_nxt = 1'b1;
      end
      if (in_field) begin
        if (is_digit && !stop_base) begin
          stopped_nxt = stop_base;
          case ({comma_r == nrmc_pkg::FIELD_DATE, pair})
            3'b000:  hour_nxt   = acc_new;
            3'b001:  minute_nxt = acc_new;
            3'b010:  second_nxt = acc_new;
            3'b100:  day_nxt    = acc_new;
            3'b101:  month_nxt  = acc_new;
            3'b110:  year_nxt   = acc_new;
            default: ;
          endcase
        end else begin
          stopped_nxt = 1'b1;
        end
      end
      if (pos_r < nrmc_pkg::POS_MAX) begin
        pos_nxt = pos_r + 3'd1;
      end
    end

    if (!dollar_nxt || !found_nxt) begin
      status_nxt = nrmc_pkg::STATUS_INVALID;
    end else if (!active_nxt || comma_nxt < nrmc_pkg::FIELD_DATE) begin
      status_nxt = nrmc_pkg::STATUS_ERROR;
    end else begin
      status_nxt = nrmc_pkg::STATUS_OK;
    end
  end

  // sentence state: advance on each character, clear after the final one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r   <= 1'b1;
      dollar_r  <= 1'b0;
      comma_r   <= 4'd0;
      pos_r     <= 3'd0;
      active_r  <= 1'b0;
      stopped_r <= 1'b0;
      hour_r    <= 7'd0;
      minute_r  <= 7'd0;
      second_r  <= 7'd0;
      day_r     <= 7'd0;
      month_r   <= 7'd0;
      year_r    <= 7'd0;
    end else if (take) begin
      if (last) begin
        first_r   <= 1'b1;
        dollar_r  <= 1'b0;
        comma_r   <= 4'd0;
        pos_r     <= 3'd0;
        active_r  <= 1'b0;
        stopped_r <= 1'b0;
        hour_r    <= 7'd0;
        minute_r  <= 7'd0;
        second_r  <= 7'd0;
        day_r     <= 7'd0;
        month_r   <= 7'd0;
        year_r    <= 7'd0;
      end else begin
        first_r   <= first_nxt;
        dollar_r  <= dollar_nxt;
        comma_r   <= comma_nxt;
        pos_r     <= pos_nxt;
        active_r  <= active_nxt;
        stopped_r <= stopped_nxt;
        hour_r    <= hour_nxt;
        minute_r  <= minute_nxt;
        second_r  <= second_nxt;
        day_r     <= day_nxt;
        month_r   <= month_nxt;
        year_r    <= year_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= 6'd0;
    end else if (cfg_we) begin
      offset_r <= cfg_wdata;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (last) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (last) begin
      status_r <= status_nxt;
      if (status_nxt == nrmc_pkg::STATUS_OK) begin
        o_hour_r   <= hour_nxt;
        o_minute_r <= minute_nxt;
        o_second_r <= 8'(second_nxt) + 8'(offset_r);
        o_day_r    <= day_nxt;
        o_month_r  <= month_nxt;
        o_year_r   <= 12'(year_nxt) + nrmc_pkg::YEAR_BASE;
      end else begin
        o_hour_r   <= 7'd0;
        o_minute_r <= 7'd0;
        o_second_r <= 8'd0;
        o_day_r    <= 7'd0;
        o_month_r  <= 7'd0;
        o_year_r   <= 12'd0;
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = status_r;
  assign out_hours   = o_hour_r;
  assign out_minutes = o_minute_r;
  assign out_seconds = o_second_r;
  assign out_day     = o_day_r;
  assign out_month   = o_month_r;
  assign out_year    = o_year_r;

`ifndef SYNTHESIS
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    last |=> out_valid_r)
    else $error("final character did not produce a result");

  a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    last |=> (first_r && comma_r == 4'd0 && pos_r == 3'd0 && !active_r))
    else $error("sentence state not cleared after final character");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r != nrmc_pkg::STATUS_OK) |->
      (o_hour_r == 7'd0 && o_second_r == 8'd0 && o_year_r == 12'd0))
    else $error("failed sentence carries nonzero time fields");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input held off with empty result register");
`endif

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for nmea_rmc_time_date_parser: streams NMEA sentences
// one character per request, predicts each time/date result and compares it.
// Depends on nrmc_pkg and the parser RTL.
module tb_top;

  localparam logic [39:0] HDR_WORD = "GPRMC";
  localparam int unsigned RUN_LIMIT = 4_000_000;
  localparam int unsigned HOLD_CYCLES = 100;

  typedef struct {
    nrmc_pkg::status_t status;
    logic [6:0]  hours;
    logic [6:0]  minutes;
    logic [7:0]  seconds;
    logic [6:0]  day;
    logic [6:0]  month;
    logic [11:0] year;
  } rmc_fix_t;

  class rmc_fix_scoreboard;
    rmc_fix_t    pending_fixes[$];
    logic [5:0]  sec_offset;
    int unsigned fail_count;
    bit          first_char;
    bit          dollar_seen;
    bit          hdr_found;
    bit          active_seen;
    bit          pair_stop;
    logic [2:0]  hdr_pos;
    logic [3:0]  commas;
    logic [2:0]  fpos;
    logic [6:0]  acc[6];  // hh mm ss dd mo yy

    function new();
      sec_offset = '0;
      fail_count = 0;
      clear_line();
    endfunction

    function void clear_line();
      first_char  = 1'b1;
      dollar_seen = 1'b0;
      hdr_found   = 1'b0;
      active_seen = 1'b0;
      pair_stop   = 1'b0;
      hdr_pos     = '0;
      commas      = '0;
      fpos        = '0;
      foreach (acc[i]) acc[i] = '0;
    endfunction

    // advance the parse by one accepted character; queue a fix at end of line
    function void parse_char(logic [7:0] c, bit eos);
      logic [2:0] p;
      int         slot;
      rmc_fix_t   fix;
      if (first_char) begin
        dollar_seen = (c == nrmc_pkg::CHAR_DOLLAR);
        first_char  = 1'b0;
      end
      if (!hdr_found) begin
        if (c == HDR_WORD[8*(4-hdr_pos) +: 8]) hdr_pos = hdr_pos + 3'd1;
        else hdr_pos = (c == nrmc_pkg::CHAR_G) ? 3'd1 : 3'd0;
        if (hdr_pos >= nrmc_pkg::HDR_LEN) begin
          hdr_found = 1'b1;
          hdr_pos   = '0;
        end
      end
      if (c == nrmc_pkg::CHAR_COMMA) begin
        if (commas != nrmc_pkg::COMMA_MAX) commas = commas + 4'd1;
        fpos      = '0;
        pair_stop = 1'b0;
      end else begin
        p = fpos;
        if (commas == nrmc_pkg::FIELD_ACTIVE && p == 3'd0 && c == nrmc_pkg::CHAR_A)
          active_seen = 1'b1;
        if (p < nrmc_pkg::POS_LIMIT &&
            (commas == nrmc_pkg::FIELD_TIME || commas == nrmc_pkg::FIELD_DATE)) begin
          slot = int'(p >> 1) + ((commas == nrmc_pkg::FIELD_DATE) ? 3 : 0);
          if (!p[0]) pair_stop = 1'b0;
          // atoi on a pair: the first non-digit freezes the value
          if (c >= nrmc_pkg::CHAR_0 && c <= nrmc_pkg::CHAR_9 && !pair_stop)
            acc[slot] = acc[slot] * 10 + (c - nrmc_pkg::CHAR_0);
          else
            pair_stop = 1'b1;
        end
        if (fpos < nrmc_pkg::POS_MAX) fpos = fpos + 3'd1;
      end
      if (!eos) return;
      fix = '{default: '0};
      if (!dollar_seen || !hdr_found) begin
        fix.status = nrmc_pkg::STATUS_INVALID;
      end else if (!active_seen || commas < nrmc_pkg::FIELD_DATE) begin
        fix.status = nrmc_pkg::STATUS_ERROR;
      end else begin
        fix.status  = nrmc_pkg::STATUS_OK;
        fix.hours   = acc[0];
        fix.minutes = acc[1];
        fix.seconds = {1'b0, acc[2]} + {2'b00, sec_offset};
        fix.day     = acc[3];
        fix.month   = acc[4];
        fix.year    = nrmc_pkg::YEAR_BASE + {5'b0, acc[5]};
      end
      pending_fixes.push_back(fix);
      clear_line();
    endfunction

    function void cmp(string name, logic [11:0] exp_v, logic [11:0] got_v);
      if (got_v !== exp_v) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
        fail_count++;
      end
    endfunction

    function void check_fix(rmc_fix_t got);
      rmc_fix_t want;
      if (pending_fixes.size() == 0) begin
        $display("%0t: result with no sentence pending, expected none, actual status %0d",
                 $time, got.status);
        fail_count++;
        return;
      end
      want = pending_fixes.pop_front();
      cmp("status",  want.status,  got.status);
      cmp("hours",   want.hours,   got.hours);
      cmp("minutes", want.minutes, got.minutes);
      cmp("seconds", want.seconds, got.seconds);
      cmp("day",     want.day,     got.day);
      cmp("month",   want.month,   got.month);
      cmp("year",    want.year,    got.year);
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [5:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_char_byte = '0;
  logic        in_end_of_sentence = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [6:0]  out_hours;
  logic [6:0]  out_minutes;
  logic [7:0]  out_seconds;
  logic [6:0]  out_day;
  logic [6:0]  out_month;
  logic [11:0] out_year;

  rmc_fix_scoreboard sb = new();
  logic [7:0] line_q[$];
  bit tx_gaps = 1'b0;
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  bit rx_hold_req = 1'b0;

  string directed_lines[14] = '{
    "$GPRMC,000000,A,,,,,,,000000",
    "$GPRMC,995999.99,A,,,,,,,311299",
    "$GPRMC,1x2 3-,A,,,,,,,x1+2 4",
    "$GPRMC,12,A,,,,,,,3",
    "$GPRMC,1234567890,A,,,,,,,010203040506",
    "$GPRMC,123456,V,,,,,,,010124",
    "$GPRMC,123456,A",
    "$GPRMC,1",
    "GPRMC,123456,A,,,,,,,010124",
    "$GPGGA,123456,A,,,,,,,010124",
    "$xGGPRMC,101010,A,,,,,,,101010",
    "$,,,,,,,,,GPRMC",
    "$GPRMC,235959,A,,,,,,,,,,,,,,,,,,,,,99",
    "$"
  };

  nmea_rmc_time_date_parser u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_char_byte       (in_char_byte),
    .in_end_of_sentence (in_end_of_sentence),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_hours          (out_hours),
    .out_minutes        (out_minutes),
    .out_seconds        (out_seconds),
    .out_day            (out_day),
    .out_month          (out_month),
    .out_year           (out_year)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT);
    $display("tb_top NOT OK");
    $finish;
  end

  always @(posedge clk) begin : result_mon
    rmc_fix_t got;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_status, out_hours, out_minutes, out_seconds, out_day, out_month, out_year};
      sb.check_fix(got);
    end
  end

  // receiver: random stall and run bursts, one long hold on request
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (rx_quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else if ($urandom_range(0, 9) == 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(20, 60)) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endfunction

  function automatic void put_pair(int v);
    line_q.push_back(8'(nrmc_pkg::CHAR_0 + v / 10));
    line_q.push_back(8'(nrmc_pkg::CHAR_0 + v % 10));
  endfunction

  function automatic logic [7:0] rand_char();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 8'(nrmc_pkg::CHAR_0 + $urandom_range(0, 9));
      5:             return 8'($urandom_range(65, 90));
      6:             return ".";
      7:             return " ";
      8:             return "-";
      default:       return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void put_junk(int n);
    repeat (n) line_q.push_back(rand_char());
  endfunction

  function automatic void put_clock(bit with_frac);
    if ($urandom_range(0, 3) != 0) begin
      repeat (3) put_pair($urandom_range(0, 99));
      if (with_frac && $urandom_range(0, 1) == 1) begin
        put_text(".");
        put_pair($urandom_range(0, 99));
      end
    end else begin
      put_junk($urandom_range(0, 9));
    end
  endfunction

  // mostly well-formed RMC lines with random content, some broken or noise
  function automatic void build_rmc_line();
    int n_fields;
    bit hdr_late;
    hdr_late = 1'b0;
    line_q.delete();
    if ($urandom_range(0, 99) < 6) begin
      repeat ($urandom_range(1, 16)) line_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    case ($urandom_range(0, 19))
      0:       line_q.push_back(8'($urandom_range(0, 255)));
      1:       ;
      default: put_text("$");
    endcase
    case ($urandom_range(0, 19))
      0:       put_text("GPGGA");
      1:       put_text("GGPRMC");
      2:       put_text("GPRGPRMC");
      3:       put_text("GPRM");
      4: begin
        put_text("XX");
        hdr_late = 1'b1;
      end
      default: put_text("GPRMC");
    endcase
    n_fields = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 12;
    for (int f = 1; f <= n_fields; f++) begin
      put_text(",");
      if (f == 1) begin
        put_clock(1'b1);
      end else if (f == 2) begin
        case ($urandom_range(0, 9))
          0:       put_text("V");
          1:       line_q.push_back(rand_char());
          2:       ;
          3:       put_text(" A");
          default: put_text("A");
        endcase
      end else if (f == 9) begin
        put_clock(1'b0);
      end else if (f == 4 && hdr_late) begin
        put_text("GPRMC");
      end else begin
        put_junk($urandom_range(0, 6));
      end
    end
    if ($urandom_range(0, 1) == 1) begin
      put_text("*");
      put_junk(2);
    end
    if ($urandom_range(0, 9) == 0 && line_q.size() > 0)
      line_q[$urandom_range(0, line_q.size() - 1)] = 8'($urandom_range(0, 255));
  endfunction

  task automatic send_char(input logic [7:0] c, input bit eos);
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_char_byte       <= c;
    in_end_of_sentence <= eos;
    do @(posedge clk); while (in_stall);
    sb.parse_char(c, eos);
  endtask

  task automatic send_line();
    tx_gaps = !tx_quiet && ($urandom_range(0, 2) != 0);
    foreach (line_q[i]) send_char(line_q[i], i == line_q.size() - 1);
  endtask

  // drop valid, wait for every pending fix, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_fixes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_offset(input logic [5:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.sec_offset = v;
  endtask

  task automatic run_phase(input int quota);
    int sent;
    sent = 0;
    while (sent < quota) begin
      build_rmc_line();
      send_line();
      sent += line_q.size();
    end
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_offset(6'd0);
    foreach (directed_lines[i]) begin
      line_q.delete();
      put_text(directed_lines[i]);
      send_line();
    end
    // NUL and 0xFF are ordinary non-digits
    line_q.delete();
    put_text("$GPRMC,1");
    line_q.push_back(8'h00);
    put_text("2,A,,,,,,,0");
    line_q.push_back(8'hFF);
    put_text("10203");
    send_line();

    write_offset(6'd63);
    run_phase(120);

    // hold the result side off while short lines keep arriving
    write_offset(6'd60);
    rx_hold_req = 1'b1;
    repeat (24) begin
      line_q.delete();
      if ($urandom_range(0, 2) != 0) put_text("$");
      else put_text("$GPRMC,595959,A,,,,,,,311299");
      send_line();
    end
    run_phase(100);

    write_offset(6'($urandom_range(0, 63)));
    run_phase(120);
    write_offset(6'd1);
    run_phase(120);
    write_offset(6'($urandom_range(2, 59)));
    run_phase(120);

    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    write_offset(6'($urandom_range(0, 63)));
    run_phase(100);

    drain();
    repeat (10) @(posedge clk);
    if (sb.fail_count == 0 && sb.pending_fixes.size() == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule
